### rtl/core/sha1s_pkg.sv
// Shared constants and sequencer state type for the SHA-1 stream hasher.
package sha1s_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned FILL_W   = 6;
    localparam int unsigned LEN_W    = 64;
    localparam int unsigned ROUND_W  = 7;
    localparam int unsigned WIN_D    = 16;
    localparam int unsigned CHAIN_D  = 5;

    localparam logic [WORD_W-1:0] H0_INIT = 32'h6745_2301;
    localparam logic [WORD_W-1:0] H1_INIT = 32'hEFCD_AB89;
    localparam logic [WORD_W-1:0] H2_INIT = 32'h98BA_DCFE;
    localparam logic [WORD_W-1:0] H3_INIT = 32'h1032_5476;
    localparam logic [WORD_W-1:0] H4_INIT = 32'hC3D2_E1F0;

    localparam logic [WORD_W-1:0] K_CH  = 32'h5A82_7999;
    localparam logic [WORD_W-1:0] K_PA1 = 32'h6ED9_EBA1;
    localparam logic [WORD_W-1:0] K_MAJ = 32'h8F1B_BCDC;
    localparam logic [WORD_W-1:0] K_PA2 = 32'hCA62_C1D6;

    localparam logic [BYTE_W-1:0]  PAD_MARKER = 8'h80;
    localparam logic [FILL_W-1:0]  LEN_POS    = 6'd56;
    localparam logic [FILL_W-1:0]  FILL_LAST  = 6'd63;
    localparam logic [ROUND_W-1:0] ROUND_LAST = 7'd79;
    localparam logic [ROUND_W-1:0] ROUND_PA1  = 7'd20;
    localparam logic [ROUND_W-1:0] ROUND_MAJ  = 7'd40;
    localparam logic [ROUND_W-1:0] ROUND_PA2  = 7'd60;
    localparam logic [2:0]         WORD_LAST  = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD_MARK,
        ST_PAD_ZERO,
        ST_PAD_LEN,
        ST_COMPRESS,
        ST_FOLD,
        ST_OUTPUT
    } sha1s_state_t;

endpackage

### rtl/core/sha1_stream_hasher.sv
// SHA-1 byte-stream hasher: block window, round sequencer and digest output.
//
//  channel | direction | beat contents                              | handshake
//  s_      | in        | message_byte, byte_present, message_end    | s_valid / s_ready
//  m_      | out       | digest_word (H0..H4), digest_last on H4    | m_valid / m_ready
//
// A data byte is shifted into the block window; every 64th byte also runs the
// rounds and the fold on the single shared round adder, while input is held off.
// Closing a message shifts in padding a byte at a time (up to 72 bytes), runs
// one or two compressions and then holds the five digest beats until taken.
// s_ready is low from the end beat until the last digest beat is taken.
// Reset (aresetn, synchronous) restores the initial chaining value and
// clears fill count and bit length; the block window needs no clearing.
module sha1_stream_hasher (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_message_byte,
    input  logic        s_byte_present,
    input  logic        s_message_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic        m_digest_last
);
    import sha1s_pkg::*;

    sha1s_state_t state_reg, state_next;
    sha1s_state_t after_reg, after_next;

    logic [FILL_W-1:0]  fill_reg;
    logic [LEN_W-1:0]   bits_reg;
    logic [ROUND_W-1:0] round_reg;
    logic [2:0]         len_cnt_reg;
    logic [2:0]         out_idx_reg;

    logic [WORD_W-1:0] w_reg [WIN_D];
    logic [WORD_W-1:0] h_reg [CHAIN_D];
    logic [WORD_W-1:0] a_reg, b_reg, c_reg, d_reg, e_reg;

    logic              accept;
    logic              shift_en;
    logic [BYTE_W-1:0] shift_byte;
    logic              bits_inc;
    logic              len_shift;
    logic              wrap;
    logic              round_en;
    logic              fold_en;
    logic              restart;

    logic [WORD_W-1:0] f_val;
    logic [WORD_W-1:0] k_val;
    logic [WORD_W-1:0] t_val;
    logic [WORD_W-1:0] sched_x;
    logic [WORD_W-1:0] sched_new;

    // Control outputs for the current state
    always_comb begin
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        shift_en   = 1'b0;
        shift_byte = '0;
        bits_inc   = 1'b0;
        len_shift  = 1'b0;
        round_en   = 1'b0;
        fold_en    = 1'b0;
        restart    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid && s_byte_present) begin
                    shift_en   = 1'b1;
                    shift_byte = s_message_byte;
                    bits_inc   = 1'b1;
                end
            end
            ST_PAD_MARK: begin
                shift_en   = 1'b1;
                shift_byte = PAD_MARKER;
            end
            ST_PAD_ZERO: begin
                if (fill_reg != LEN_POS) begin
                    shift_en = 1'b1;
                end
            end
            ST_PAD_LEN: begin
                shift_en   = 1'b1;
                shift_byte = bits_reg[LEN_W-1 -: BYTE_W];
                len_shift  = 1'b1;
            end
            ST_COMPRESS: begin
                round_en = 1'b1;
            end
            ST_FOLD: begin
                fold_en = 1'b1;
            end
            ST_OUTPUT: begin
                m_valid = 1'b1;
                if (m_ready && out_idx_reg == WORD_LAST) begin
                    restart = 1'b1;
                end
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    assign accept = s_valid && s_ready;
    assign wrap   = shift_en && (fill_reg == FILL_LAST);

    // Sequencer next state
    always_comb begin
        state_next = state_reg;
        after_next = after_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (wrap) begin
                        state_next = ST_COMPRESS;
                        after_next = s_message_end ? ST_PAD_MARK : ST_IDLE;
                    end else if (s_message_end) begin
                        state_next = ST_PAD_MARK;
                    end
                end
            end
            ST_PAD_MARK: begin
                state_next = wrap ? ST_COMPRESS : ST_PAD_ZERO;
                after_next = ST_PAD_ZERO;
            end
            ST_PAD_ZERO: begin
                if (fill_reg == LEN_POS) begin
                    state_next = ST_PAD_LEN;
                end else if (wrap) begin
                    state_next = ST_COMPRESS;
                    after_next = ST_PAD_ZERO;
                end
            end
            ST_PAD_LEN: begin
                if (wrap) begin
                    state_next = ST_COMPRESS;
                    after_next = ST_OUTPUT;
                end
            end
            ST_COMPRESS: begin
                if (round_reg == ROUND_LAST) begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                state_next = after_reg;
            end
            ST_OUTPUT: begin
                if (restart) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Round function and constant for the current round
    always_comb begin
        priority if (round_reg < ROUND_PA1) begin
            f_val = (b_reg & c_reg) ^ (~b_reg & d_reg);
            k_val = K_CH;
        end else if (round_reg < ROUND_MAJ) begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_PA1;
        end else if (round_reg < ROUND_PA2) begin
            f_val = (b_reg & c_reg) ^ (b_reg & d_reg) ^ (c_reg & d_reg);
            k_val = K_MAJ;
        end else begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_PA2;
        end
    end

    // Shared round adder and schedule word
    assign t_val     = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + w_reg[0];
    assign sched_x   = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
    assign sched_new = {sched_x[30:0], sched_x[31]};

    // Digest word select
    always_comb begin
        unique case (out_idx_reg)
            3'd0:    m_digest_word = h_reg[0];
            3'd1:    m_digest_word = h_reg[1];
            3'd2:    m_digest_word = h_reg[2];
            3'd3:    m_digest_word = h_reg[3];
            default: m_digest_word = h_reg[4];
        endcase
    end
    assign m_digest_last = (out_idx_reg == WORD_LAST);

    // Control registers, chaining value and length
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            after_reg   <= ST_IDLE;
            fill_reg    <= '0;
            bits_reg    <= '0;
            round_reg   <= '0;
            len_cnt_reg <= '0;
            out_idx_reg <= '0;
            h_reg[0]    <= H0_INIT;
            h_reg[1]    <= H1_INIT;
            h_reg[2]    <= H2_INIT;
            h_reg[3]    <= H3_INIT;
            h_reg[4]    <= H4_INIT;
        end else begin
            state_reg <= state_next;
            after_reg <= after_next;
            if (shift_en) begin
                fill_reg <= fill_reg + 1'b1;
            end
            // advance the bit length, or drain it msb first during padding
            if (bits_inc) begin
                bits_reg <= bits_reg + LEN_W'(8);
            end else if (len_shift) begin
                bits_reg <= {bits_reg[LEN_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
            end
            if (len_shift) begin
                len_cnt_reg <= len_cnt_reg + 1'b1;
            end
            if (wrap) begin
                round_reg <= '0;
            end else if (round_en) begin
                round_reg <= round_reg + 1'b1;
            end
            // fold working variables into the chaining value
            if (fold_en) begin
                h_reg[0] <= h_reg[0] + a_reg;
                h_reg[1] <= h_reg[1] + b_reg;
                h_reg[2] <= h_reg[2] + c_reg;
                h_reg[3] <= h_reg[3] + d_reg;
                h_reg[4] <= h_reg[4] + e_reg;
            end
            // step through digest beats, restart on the last
            if (restart) begin
                out_idx_reg <= '0;
                fill_reg    <= '0;
                bits_reg    <= '0;
                len_cnt_reg <= '0;
                h_reg[0]    <= H0_INIT;
                h_reg[1]    <= H1_INIT;
                h_reg[2]    <= H2_INIT;
                h_reg[3]    <= H3_INIT;
                h_reg[4]    <= H4_INIT;
            end else if (m_valid && m_ready) begin
                out_idx_reg <= out_idx_reg + 1'b1;
            end
        end
    end

    // Block window and working variables
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            for (int i = 0; i < WIN_D - 1; i++) begin
                w_reg[i] <= {w_reg[i][WORD_W-BYTE_W-1:0], w_reg[i+1][WORD_W-1 -: BYTE_W]};
            end
            w_reg[WIN_D-1] <= {w_reg[WIN_D-1][WORD_W-BYTE_W-1:0], shift_byte};
        end else if (round_en) begin
            for (int i = 0; i < WIN_D - 1; i++) begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[WIN_D-1] <= sched_new;
        end
        if (wrap) begin
            a_reg <= h_reg[0];
            b_reg <= h_reg[1];
            c_reg <= h_reg[2];
            d_reg <= h_reg[3];
            e_reg <= h_reg[4];
        end else if (round_en) begin
            a_reg <= t_val;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

`ifndef SYNTH
    // Input and output sides never open together
    a_ready_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid)
        else $error("s_ready and m_valid high together");

    // Last digest beat restores the message state
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_digest_last) |=>
            (s_ready && fill_reg == '0 && bits_reg == '0 && h_reg[0] == H0_INIT))
        else $error("state not restored after last digest beat");

    // Final round is followed by the fold
    a_fold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COMPRESS && round_reg == ROUND_LAST) |=> (state_reg == ST_FOLD))
        else $error("fold did not follow final round");

    // Ordinary data byte that does not fill the block leaves the input open
    a_no_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_byte_present && !s_message_end && fill_reg != FILL_LAST) |=> s_ready)
        else $error("input stalled after ordinary byte");

    // Length bytes always end exactly on a block boundary
    a_len_align: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PAD_LEN) |-> (fill_reg[5:3] == 3'b111 && fill_reg[2:0] == len_cnt_reg))
        else $error("length padding misaligned");
`endif

endmodule

### bench/tb_top.sv
// Self-checking bench for the SHA-1 byte-stream hasher with its own digest calculator.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // SHA-1 initial chaining value and round constants
    localparam logic [31:0] IV_A = 32'h6745_2301;
    localparam logic [31:0] IV_B = 32'hEFCD_AB89;
    localparam logic [31:0] IV_C = 32'h98BA_DCFE;
    localparam logic [31:0] IV_D = 32'h1032_5476;
    localparam logic [31:0] IV_E = 32'hC3D2_E1F0;
    localparam logic [31:0] RC_0 = 32'h5A82_7999;
    localparam logic [31:0] RC_1 = 32'h6ED9_EBA1;
    localparam logic [31:0] RC_2 = 32'h8F1B_BCDC;
    localparam logic [31:0] RC_3 = 32'hCA62_C1D6;
    localparam logic [7:0]  PAD_BYTE    = 8'h80;
    localparam int          LEN_OFFSET  = 56;
    localparam int          DIGEST_LEN  = 5;
    localparam int          TAIL_BEATS  = 24;
    localparam int          DRAIN_CYCLES = 400;

    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       closes;
    } msg_beat_t;

    typedef struct packed {
        logic [31:0] word;
        logic        tail;
    } digest_beat_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_message_byte = 8'h00;
    logic        s_byte_present = 1'b0;
    logic        s_message_end = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_digest_word;
    logic        m_digest_last;

    sha1_stream_hasher u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_message_byte (s_message_byte),
        .s_byte_present (s_byte_present),
        .s_message_end  (s_message_end),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_digest_word  (m_digest_word),
        .m_digest_last  (m_digest_last)
    );

    // Stimulus and expected digest words
    msg_beat_t    pending_beats[$];
    digest_beat_t digest_due[$];
    int           real_beats;

    // Calculator state
    logic [31:0] chain[5];
    logic [7:0]  window[64];
    logic [5:0]  fill;
    logic [63:0] bit_len;

    // Run statistics
    int          mismatches = 0;
    int          beats_taken = 0;
    int          messages_closed = 0;
    int          words_checked = 0;

    // Idle control
    logic        tail_quiet = 1'b0;
    int          src_gap = 0;
    int          src_phase = 0;
    logic        src_idle_on = 1'b0;
    int          snk_stall = 0;
    int          snk_phase = 0;
    logic        snk_idle_on = 1'b0;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    task automatic restart_chain();
        chain[0] = IV_A;
        chain[1] = IV_B;
        chain[2] = IV_C;
        chain[3] = IV_D;
        chain[4] = IV_E;
        fill     = '0;
        bit_len  = '0;
    endtask

    // Fold the 64-byte window into the chaining value
    task automatic compress_window();
        logic [31:0] w[80];
        logic [31:0] a, b, c, d, e, f, k, t;
        int r;
        for (r = 0; r < 16; r++) begin
            w[r] = {window[4*r], window[4*r+1], window[4*r+2], window[4*r+3]};
        end
        for (r = 16; r < 80; r++) begin
            w[r] = rotl(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
        end
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        e = chain[4];
        for (r = 0; r < 80; r++) begin
            if (r < 20) begin
                f = (b & c) ^ (~b & d);
                k = RC_0;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = RC_1;
            end else if (r < 60) begin
                f = (b & c) ^ (b & d) ^ (c & d);
                k = RC_2;
            end else begin
                f = b ^ c ^ d;
                k = RC_3;
            end
            t = rotl(a, 5) + f + e + k + w[r];
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = t;
        end
        chain[0] = chain[0] + a;
        chain[1] = chain[1] + b;
        chain[2] = chain[2] + c;
        chain[3] = chain[3] + d;
        chain[4] = chain[4] + e;
    endtask

    // Absorb one accepted beat; on message end pad, finish and queue the digest
    task automatic hash_beat(input msg_beat_t bt);
        int pos;
        int i;
        digest_beat_t dw;
        if (bt.present) begin
            window[fill] = bt.data;
            fill         = fill + 6'd1;
            bit_len      = bit_len + 64'd8;
            if (fill == 6'd0) compress_window();
        end
        if (bt.closes) begin
            pos = fill;
            window[pos] = PAD_BYTE;
            pos++;
            if (pos > LEN_OFFSET) begin
                while (pos < 64) begin
                    window[pos] = 8'h00;
                    pos++;
                end
                compress_window();
                pos = 0;
            end
            while (pos < LEN_OFFSET) begin
                window[pos] = 8'h00;
                pos++;
            end
            for (i = 0; i < 8; i++) begin
                window[63-i] = bit_len[8*i +: 8];
            end
            compress_window();
            for (i = 0; i < DIGEST_LEN; i++) begin
                dw.word = chain[i];
                dw.tail = (i == DIGEST_LEN - 1);
                digest_due.push_back(dw);
            end
            restart_chain();
        end
    endtask

    task automatic push_beat(input logic [7:0] data, input logic present, input logic closes);
        msg_beat_t bt;
        bt.data    = data;
        bt.present = present;
        bt.closes  = closes;
        pending_beats.push_back(bt);
        if (present || closes) real_beats++;
    endtask

    // Queue one message of len bytes, closed by its last byte or by a bare end marker
    task automatic add_message(input int len, input logic bare_end);
        int i;
        for (i = 0; i < len; i++) begin
            if ($urandom_range(0, 11) == 0) push_beat(8'($urandom), 1'b0, 1'b0);
            push_beat(8'($urandom), 1'b1, (i == len - 1) && !bare_end);
        end
        if (bare_end || len == 0) push_beat(8'($urandom), 1'b0, 1'b1);
    endtask

    // Clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Run limit
    initial begin
        #5ms;
        $display("timeout with %0d digest words outstanding", digest_due.size());
        $display("FAILED: results differ");
        $finish;
    end

    // Source driver: hold each beat until taken, insert idle bursts between beats
    always @(posedge aclk) begin
        msg_beat_t nxt;
        logic      fire;
        logic      next_valid;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            fire = s_valid && s_ready;
            if (fire) begin
                nxt.data    = s_message_byte;
                nxt.present = s_byte_present;
                nxt.closes  = s_message_end;
                hash_beat(nxt);
                beats_taken++;
                if (nxt.closes) messages_closed++;
            end
            if (src_phase == 0) begin
                src_phase   = $urandom_range(20, 90);
                src_idle_on = ($urandom_range(0, 2) != 0);
            end else begin
                src_phase--;
            end
            if (!s_valid || fire) begin
                next_valid = 1'b0;
                if (src_gap > 0) begin
                    src_gap--;
                end else if (pending_beats.size() > 0) begin
                    nxt = pending_beats.pop_front();
                    s_message_byte <= nxt.data;
                    s_byte_present <= nxt.present;
                    s_message_end  <= nxt.closes;
                    next_valid     = 1'b1;
                    if (pending_beats.size() < TAIL_BEATS) tail_quiet <= 1'b1;
                    if (src_idle_on && !tail_quiet && $urandom_range(0, 3) == 0)
                        src_gap = $urandom_range(1, 16);
                end
                s_valid <= next_valid;
            end
        end
    end

    // Result monitor: check each digest beat, stall the result channel in bursts
    always @(posedge aclk) begin
        digest_beat_t exp_beat;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (digest_due.size() == 0) begin
                    $display("%0t: digest beat with nothing expected: word %08h last %0b",
                             $time, m_digest_word, m_digest_last);
                    mismatches++;
                end else begin
                    exp_beat = digest_due.pop_front();
                    words_checked++;
                    if (m_digest_word !== exp_beat.word) begin
                        $display("%0t: digest_word mismatch: expected %08h, actual %08h",
                                 $time, exp_beat.word, m_digest_word);
                        mismatches++;
                    end
                    if (m_digest_last !== exp_beat.tail) begin
                        $display("%0t: digest_last mismatch: expected %0b, actual %0b",
                                 $time, exp_beat.tail, m_digest_last);
                        mismatches++;
                    end
                end
            end
            if (snk_phase == 0) begin
                snk_phase   = $urandom_range(20, 90);
                snk_idle_on = ($urandom_range(0, 2) != 0);
            end else begin
                snk_phase--;
            end
            if (snk_stall > 0) begin
                snk_stall--;
                m_ready <= 1'b0;
            end else if (snk_idle_on && !tail_quiet && $urandom_range(0, 5) == 0) begin
                snk_stall = $urandom_range(0, 15);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Stimulus, reset and end of run
    initial begin
        int boundary_lens[8];
        int sel;
        int len;
        boundary_lens = '{55, 56, 57, 63, 64, 65, 119, 120};
        real_beats    = 0;
        restart_chain();
        for (int i = 0; i < 64; i++) window[i] = 8'h00;

        // Empty message by bare end marker
        push_beat(8'h00, 1'b0, 1'b1);
        // Empty item ignored, then another empty message
        push_beat(8'hFF, 1'b0, 1'b0);
        push_beat(8'hFF, 1'b0, 1'b1);
        // Single-byte messages at the byte extremes, end on the byte
        push_beat(8'h00, 1'b1, 1'b1);
        push_beat(8'hFF, 1'b1, 1'b1);
        // "abc" closed on its last byte
        push_beat(8'h61, 1'b1, 1'b0);
        push_beat(8'h62, 1'b1, 1'b0);
        push_beat(8'h63, 1'b1, 1'b1);
        // Bytes with an empty item in between, closed by a bare end marker
        push_beat(8'h80, 1'b1, 1'b0);
        push_beat(8'h55, 1'b0, 1'b0);
        push_beat(8'h7F, 1'b1, 1'b0);
        push_beat(8'hAA, 1'b0, 1'b1);

        // Random messages: mostly short, some at the padding boundaries
        while (real_beats < 180) begin
            sel = $urandom_range(0, 19);
            if (sel < 12) len = $urandom_range(0, 12);
            else if (sel < 17) len = boundary_lens[$urandom_range(0, 7)];
            else len = $urandom_range(13, 70);
            // keep the last message's byte count within the beat budget
            if (len > 190 - real_beats) len = 190 - real_beats;
            add_message(len, ($urandom_range(0, 1) == 1));
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_beats.size() != 0 || s_valid) @(posedge aclk);
        while (digest_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("run covered %0d input beats closing %0d messages, %0d digest words checked",
                 beats_taken, messages_closed, words_checked);
        $display("including empty and bare-end items, byte extremes and padding boundaries");
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
